// ===== hw/rtl/rrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and codes
// Word formats, command and result codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_ACK    = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] KIND_TX     = 3'd0;
  localparam logic [2:0] KIND_RETX   = 3'd1;
  localparam logic [2:0] KIND_DROP   = 3'd2;
  localparam logic [2:0] KIND_ACK    = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;
  localparam logic [2:0] KIND_REJECT = 3'd5;

  localparam logic CFG_ACK_TIMEOUT = 1'b0;
  localparam logic CFG_MAX_RETRIES = 1'b1;

  localparam logic [31:0] ACK_TIMEOUT_RST = 32'd1000;
  localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] current_time;
    logic [47:0] dest_endpoint;
    logic [15:0] payload_handle;
    logic [31:0] acked_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] packet_id;
    logic [47:0] out_endpoint;
    logic [15:0] out_handle;
    logic [7:0]  attempt;
    logic        ack_matched;
    logic [4:0]  drop_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] endpoint;
    logic [15:0] handle;
    logic [31:0] sent_time;
    logic [7:0]  retries;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic tick_start;
    logic scan_clr;
    logic scan_step;
    logic sel_rd;
    logic do_send;
    logic do_ack;
    logic do_proc;
    logic do_done;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       out_free;
    logic       scan_end;
    logic       found;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_ctrl: sequencer
// Steps each command word through dispatch, table sweeps and result issue.
// ----------------------------------------------------------------------------
module rrt_ctrl
  import rrt_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  stat_t st_i,
  output ctl_t  ctl_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SEND = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_TAIL = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_ACK  = 4'd6;
  localparam logic [3:0] S_PROC = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st_i.cmd)
          CMD_SEND: state_d = S_SEND;
          CMD_ACK, CMD_TICK: begin
            ctl_o.tick_start = 1'b1;
            ctl_o.scan_clr   = 1'b1;
            state_d          = S_SCAN;
          end
          CMD_UNUSED: state_d = S_IDLE;
          default: state_d = S_IDLE;
        endcase
      end
      S_SEND: begin
        if (st_i.out_free) begin
          ctl_o.do_send = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (st_i.scan_end) state_d = S_TAIL;
      end
      S_TAIL: state_d = S_CHK;
      S_CHK: begin
        ctl_o.sel_rd = st_i.found;
        priority if (st_i.cmd == CMD_ACK) begin
          state_d = S_ACK;
        end else if (st_i.found) begin
          state_d = S_PROC;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ACK: begin
        if (st_i.out_free) begin
          ctl_o.do_ack = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_PROC: begin
        if (st_i.out_free) begin
          ctl_o.do_proc  = 1'b1;
          ctl_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          ctl_o.do_done = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rrt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_dp: table datapath
// Entry memory, live bits, id allocation, sweep compare and result register.
// ----------------------------------------------------------------------------
module rrt_dp
  import rrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  ctl_t       ctl_i,
  output stat_t      st_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_word_t  out_data_o,
  input  wire        cfg_valid_i,
  input  wire        cfg_index_i,
  input  wire [31:0] cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  logic [31:0]          ack_timeout_q;
  logic [7:0]           max_retries_q;
  in_word_t             in_q;
  logic [31:0]          next_id_q;
  logic [AW-1:0]        next_slot_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  entry_t               mem [TABLE_DEPTH];
  entry_t               rd_q;
  logic [AW-1:0]        rd_slot_q;
  logic                 cmp_en_q;

  logic [AW-1:0]        addr_q;
  logic                 min_found_q;
  logic [31:0]          min_id_q;
  logic [AW-1:0]        min_slot_q;
  logic [31:0]          last_id_q;
  logic                 have_last_q;
  logic [CW-1:0]        drops_q;

  out_word_t            out_q, out_d;
  logic                 out_valid_q;

  logic                 out_free;
  logic                 slot_busy;
  logic                 live, take;
  logic [31:0]          age;
  logic                 due, drop;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, rd_addr;
  entry_t               mem_wd;

  assign out_free  = !out_valid_q || out_ready_i;
  assign slot_busy = valid_q[next_slot_q];

  assign st_o.cmd      = in_q.cmd;
  assign st_o.out_free = out_free;
  assign st_o.scan_end = (addr_q == LAST_SLOT);
  assign st_o.found    = min_found_q;

  assign age  = in_q.current_time - rd_q.sent_time;
  assign due  = (age >= ack_timeout_q);
  assign drop = (rd_q.retries >= max_retries_q);

  always_comb begin
    live = cmp_en_q && valid_q[rd_slot_q];
    if (in_q.cmd == CMD_ACK) begin
      take = live && (rd_q.id == in_q.acked_id) && (rd_q.endpoint == in_q.dest_endpoint);
    end else begin
      take = live && (!have_last_q || (rd_q.id > last_id_q)) &&
             (!min_found_q || (rd_q.id < min_id_q));
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = min_slot_q;
    mem_wd = rd_q;
    if (ctl_i.do_send && !slot_busy) begin
      mem_we           = 1'b1;
      mem_wa           = next_slot_q;
      mem_wd.id        = next_id_q;
      mem_wd.endpoint  = in_q.dest_endpoint;
      mem_wd.handle    = in_q.payload_handle;
      mem_wd.sent_time = in_q.current_time;
      mem_wd.retries   = '0;
    end else if (ctl_i.do_proc && due && !drop) begin
      mem_we           = 1'b1;
      mem_wd.sent_time = in_q.current_time;
      mem_wd.retries   = rd_q.retries + 8'd1;
    end
  end

  assign rd_addr = ctl_i.sel_rd ? min_slot_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (ctl_i.scan_step || ctl_i.sel_rd) begin
      rd_q      <= mem[rd_addr];
      rd_slot_q <= rd_addr;
    end
    if (ctl_i.latch) in_q <= in_data_i;
    if (take) begin
      min_id_q   <= rd_q.id;
      min_slot_q <= rd_slot_q;
    end
    if (ctl_i.do_proc) last_id_q <= rd_q.id;
    out_q <= out_d;
  end

  always_comb begin
    out_d = out_q;
    if (ctl_i.do_send) begin
      out_d              = '0;
      out_d.kind         = slot_busy ? KIND_REJECT : KIND_TX;
      out_d.packet_id    = next_id_q;
      out_d.out_endpoint = in_q.dest_endpoint;
      out_d.out_handle   = in_q.payload_handle;
      out_d.last         = 1'b1;
    end else if (ctl_i.do_ack) begin
      out_d              = '0;
      out_d.kind         = KIND_ACK;
      out_d.packet_id    = in_q.acked_id;
      out_d.out_endpoint = in_q.dest_endpoint;
      out_d.out_handle   = min_found_q ? rd_q.handle : 16'd0;
      out_d.ack_matched  = min_found_q;
      out_d.last         = 1'b1;
    end else if (ctl_i.do_proc && due) begin
      out_d              = '0;
      out_d.kind         = drop ? KIND_DROP : KIND_RETX;
      out_d.packet_id    = rd_q.id;
      out_d.out_endpoint = rd_q.endpoint;
      out_d.out_handle   = rd_q.handle;
      out_d.attempt      = drop ? rd_q.retries : rd_q.retries + 8'd1;
    end else if (ctl_i.do_done) begin
      out_d            = '0;
      out_d.kind       = KIND_DONE;
      out_d.drop_count = 5'(drops_q);
      out_d.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RST;
      max_retries_q <= MAX_RETRIES_RST;
      next_id_q     <= '0;
      next_slot_q   <= '0;
      valid_q       <= '0;
      cmp_en_q      <= 1'b0;
      addr_q        <= '0;
      min_found_q   <= 1'b0;
      have_last_q   <= 1'b0;
      drops_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
          CFG_MAX_RETRIES: max_retries_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      cmp_en_q <= ctl_i.scan_step;

      if (ctl_i.scan_clr) begin
        addr_q      <= '0;
        min_found_q <= 1'b0;
      end else begin
        if (ctl_i.scan_step) addr_q <= addr_q + AW'(1);
        if (take) min_found_q <= 1'b1;
      end

      if (ctl_i.tick_start) begin
        have_last_q <= 1'b0;
        drops_q     <= '0;
      end else if (ctl_i.do_proc) begin
        have_last_q <= 1'b1;
        if (due && drop) drops_q <= drops_q + CW'(1);
      end

      if (ctl_i.do_send && !slot_busy) begin
        valid_q[next_slot_q] <= 1'b1;
        next_id_q            <= next_id_q + 32'd1;
        if (next_id_q == '1 || next_slot_q == LAST_SLOT) begin
          next_slot_q <= '0;
        end else begin
          next_slot_q <= next_slot_q + AW'(1);
        end
      end else if (ctl_i.do_ack && min_found_q) begin
        valid_q[min_slot_q] <= 1'b0;
      end else if (ctl_i.do_proc && due && drop) begin
        valid_q[min_slot_q] <= 1'b0;
      end

      if (ctl_i.do_send || ctl_i.do_ack || (ctl_i.do_proc && due) || ctl_i.do_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_one_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.do_send, ctl_i.do_ack, ctl_i.do_proc, ctl_i.do_done}))
    else $error("more than one result issued in a cycle");

  a_issue_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.do_send || ctl_i.do_ack || ctl_i.do_proc || ctl_i.do_done) |-> out_free)
    else $error("result issued over a pending word");

  a_send_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.do_send && !slot_busy) |=> valid_q[$past(next_slot_q)])
    else $error("sent entry not marked live");

  a_proc_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.do_proc |-> (min_found_q && !ctl_i.scan_step))
    else $error("entry processed without a selection");

  a_drops_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drops_q <= CW'(TABLE_DEPTH))
    else $error("drop count beyond table depth");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/reliable_retransmit_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// reliable_retransmit_table: retransmission timer table
// Tracks unacknowledged packets; sends, acks and timer ticks as command words.
// ----------------------------------------------------------------------------
// One command word is handled at a time. An ack sweeps the entry memory at
// one slot per cycle. A tick visits live entries in ascending id order by a
// minimum search sweep per entry; every sweep goes through the single read
// port of the entry memory. Each result word waits in an output register,
// and further results stall while that register is held. Configuration is
// taken at any time, one write per cycle; register 0 is ack_timeout and
// register 1 is max_retries.
module reliable_retransmit_table
  import rrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_word_t  out_data_o,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire        cfg_index_i,
  input  wire [31:0] cfg_data_i
);

  ctl_t  ctl;
  stat_t st;

  assign cfg_ready_o = 1'b1;

  rrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  rrt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .st_o        (st),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire
